// ===== design/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotor cipher stage package
// Shared sizes, command codes and transaction types for the rotor stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  // The alphabet size is a power of two, so digit extraction is a shift.
  localparam int ALPHA_BITS    = 5;
  localparam int ALPHABET_SIZE = 1 << ALPHA_BITS;
  localparam int ADDR_W        = (ALPHA_BITS > 0) ? ALPHA_BITS : 1;
  localparam int POSITION_WIDTH = 32;
  localparam int LETTER_W      = 5;
  localparam int KEY_W         = (ALPHA_BITS > LETTER_W) ? ALPHA_BITS : LETTER_W;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_DECODE = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [LETTER_W-1:0] entry_index;
    logic [LETTER_W-1:0] left_value;
    logic [LETTER_W-1:0] right_value;
    logic [LETTER_W-1:0] letter;
    logic                direction;
  } cmd_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_letter;
    logic                no_match;
  } result_t;

endpackage

`default_nettype wire

// ===== design/rotor_cipher_stage_core.sv =====
// ----------------------------------------------------------------------------
// Rotor cipher stage core
// One rotor: a loadable wiring table with encode and decode step counters.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. A load
// command writes one wiring entry in that same edge and leaves busy low.
// An encode or decode command advances its step counter and raises busy.
// The rotor offset is then found by shifting the position right one digit
// per cycle until only the top digit is left, and the wiring memory is
// scanned through its single read port, one entry per cycle, over all
// ALPHABET_SIZE entries, with a drain state for the read latency. The reply
// state then forms the result, which is shown on result for exactly one
// cycle with done high.
// Busy falls in the cycle done is shown, so the next command can be taken
// at the end of that cycle.
// The receiver cannot stall, so results are never held back.
// Reset clears both step counters and the sequencer; the wiring table is not
// cleared and must be loaded before use. Kind 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module rotor_cipher_stage_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  rcs_pkg::cmd_t       cmd,
  output logic                done,
  output rcs_pkg::result_t    result
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIGIT = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_REPLY = 5'b10000
  } state_t;

  state_t state;

  logic [rcs_pkg::POSITION_WIDTH-1:0] encode_position;
  logic [rcs_pkg::POSITION_WIDTH-1:0] decode_position;
  logic [rcs_pkg::POSITION_WIDTH-1:0] pos;
  logic [rcs_pkg::KEY_W-1:0]          key;
  logic [rcs_pkg::LETTER_W-1:0]       letter;
  logic                               direction;
  logic                               is_decode;
  logic [rcs_pkg::ADDR_W-1:0]         scan_addr;
  logic                               cmp_valid;
  logic                               hit;
  logic [rcs_pkg::LETTER_W-1:0]       own;

  logic [2*rcs_pkg::LETTER_W-1:0] wiring_mem [rcs_pkg::ALPHABET_SIZE];
  logic [2*rcs_pkg::LETTER_W-1:0] mem_q;

  logic                          accept;
  logic [rcs_pkg::ALPHA_BITS-1:0] offset;
  logic [rcs_pkg::ALPHA_BITS-1:0] search;
  logic [rcs_pkg::LETTER_W-1:0]  mem_left;
  logic [rcs_pkg::LETTER_W-1:0]  mem_right;
  logic [rcs_pkg::LETTER_W-1:0]  opp_value;
  logic [rcs_pkg::LETTER_W-1:0]  own_value;
  logic [rcs_pkg::KEY_W:0]       own_ext;
  logic [rcs_pkg::KEY_W:0]       off_ext;
  logic [rcs_pkg::KEY_W:0]       diff;
  rcs_pkg::result_t              result_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign offset = pos[rcs_pkg::ALPHA_BITS-1:0];
  assign search = rcs_pkg::ALPHA_BITS'(rcs_pkg::ALPHA_BITS'(letter) + offset);

  assign mem_left  = mem_q[2*rcs_pkg::LETTER_W-1:rcs_pkg::LETTER_W];
  assign mem_right = mem_q[rcs_pkg::LETTER_W-1:0];
  assign opp_value = direction ? mem_left : mem_right;
  assign own_value = direction ? mem_right : mem_left;

  assign own_ext = (rcs_pkg::KEY_W + 1)'(own);
  assign off_ext = (rcs_pkg::KEY_W + 1)'(offset);

  always_comb begin
    if (own_ext >= off_ext) begin
      diff = own_ext - off_ext;
    end else begin
      diff = own_ext + (rcs_pkg::KEY_W + 1)'(rcs_pkg::ALPHABET_SIZE) - off_ext;
    end
    if (!hit) begin
      result_next.out_letter = '0;
      result_next.no_match   = 1'b1;
    end else if (is_decode) begin
      result_next.out_letter = rcs_pkg::LETTER_W'(diff);
      result_next.no_match   = 1'b0;
    end else begin
      result_next.out_letter = own;
      result_next.no_match   = 1'b0;
    end
  end

  // Wiring memory: one write port for loads, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (accept && cmd.kind == rcs_pkg::KIND_LOAD
        && int'(cmd.entry_index) < rcs_pkg::ALPHABET_SIZE) begin
      wiring_mem[rcs_pkg::ADDR_W'(cmd.entry_index)] <= {cmd.left_value, cmd.right_value};
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= wiring_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      encode_position <= '0;
      decode_position <= '0;
      done            <= 1'b0;
      cmp_valid       <= 1'b0;
    end else begin
      done      <= 1'b0;
      cmp_valid <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd.kind)
              rcs_pkg::KIND_ENCODE: begin
                encode_position <= encode_position + rcs_pkg::POSITION_WIDTH'(1);
                pos             <= encode_position + rcs_pkg::POSITION_WIDTH'(1);
                is_decode       <= 1'b0;
                state           <= ST_DIGIT;
              end
              rcs_pkg::KIND_DECODE: begin
                decode_position <= decode_position + rcs_pkg::POSITION_WIDTH'(1);
                pos <= cmd.direction ? decode_position
                                     : decode_position + rcs_pkg::POSITION_WIDTH'(2);
                is_decode       <= 1'b1;
                state           <= ST_DIGIT;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
            letter    <= cmd.letter;
            direction <= cmd.direction;
            key       <= rcs_pkg::KEY_W'(cmd.letter);
          end
        end
        ST_DIGIT: begin
          if ((pos >> rcs_pkg::ALPHA_BITS) != '0) begin
            pos <= pos >> rcs_pkg::ALPHA_BITS;
          end else begin
            if (!is_decode) begin
              key <= rcs_pkg::KEY_W'(search);
            end
            hit       <= 1'b0;
            own       <= '0;
            scan_addr <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_addr <= scan_addr + rcs_pkg::ADDR_W'(1);
          if (scan_addr == rcs_pkg::ADDR_W'(rcs_pkg::ALPHABET_SIZE - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_REPLY;
        end
        ST_REPLY: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmp_valid && rcs_pkg::KEY_W'(opp_value) == key) begin
        hit <= 1'b1;
        own <= own_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_REPLY) begin
      result <= result_next;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done was high for two cycles in a row");

  a_letter_starts_work: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.kind == rcs_pkg::KIND_ENCODE || cmd.kind == rcs_pkg::KIND_DECODE))
      |=> busy)
    else $error("encode or decode transaction did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == rcs_pkg::KIND_LOAD) |=> !busy && !done)
    else $error("load transaction started work or produced a result");

  a_reply_gives_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLY) |=> done && !busy)
    else $error("reply state did not present a result");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.no_match) |-> result.out_letter == '0)
    else $error("unmatched result carries a nonzero letter");

endmodule

`default_nettype wire
